### rtl/lcs_pkg.sv
// Shared types for the LCS length engine.
// No dependencies; used by lcs_cell, lcs_length and lcs_length_checker.
package lcs_pkg;

  typedef struct packed {
    logic vld;
    logic last;
  } wave_ctl_t;

  localparam int unsigned SymW = 8;
  localparam int unsigned OutLenW = 9;

endpackage

### rtl/lcs_cell.sv
// One cell of the LCS row: holds one A symbol and its match length.
// Passes the B wave (symbol, left, diag) to the next cell each cycle. Uses lcs_pkg.
module lcs_cell #(
  parameter int unsigned LenW = 9
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lcs_pkg::wave_ctl_t      ctl_i,
  input  logic [7:0]              b_i,
  input  logic [LenW-1:0]         left_i,
  input  logic [LenW-1:0]         diag_i,
  input  logic                    load_i,
  input  logic [7:0]              a_sym_i,
  input  logic                    clr_i,
  input  logic                    prev_full_i,
  output logic                    full_o,
  output lcs_pkg::wave_ctl_t      ctl_o,
  output logic [7:0]              b_o,
  output logic [LenW-1:0]         left_o,
  output logic [LenW-1:0]         diag_o
);
  import lcs_pkg::*;

  logic            full_q, full_d;
  logic [SymW-1:0] a_q;
  logic [LenW-1:0] val_q, val_d;
  logic            take;
  logic            hit;
  logic [LenW-1:0] cell_val;
  wave_ctl_t       ctl_q;
  logic [7:0]      b_q;
  logic [LenW-1:0] left_q, left_d, diag_q, diag_d;

  assign take = load_i & prev_full_i & ~full_q;
  assign hit  = ctl_i.vld & full_q;

  always_comb begin
    if (a_q == b_i) begin
      cell_val = diag_i + LenW'(1);
    end else if (val_q > left_i) begin
      cell_val = val_q;
    end else begin
      cell_val = left_i;
    end
  end

  always_comb begin
    full_d = full_q;
    if (clr_i) begin
      full_d = 1'b0;
    end else if (take) begin
      full_d = 1'b1;
    end
  end

  always_comb begin
    val_d  = val_q;
    left_d = left_i;
    diag_d = diag_i;
    if (take) begin
      val_d = '0;
    end else if (hit) begin
      val_d  = cell_val;
      left_d = cell_val;
      diag_d = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      ctl_q  <= '0;
    end else begin
      full_q <= full_d;
      ctl_q  <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_q <= a_sym_i;
    end
    val_q  <= val_d;
    b_q    <= b_i;
    left_q <= left_d;
    diag_q <= diag_d;
  end

  assign full_o = full_q;
  assign ctl_o  = ctl_q;
  assign b_o    = b_q;
  assign left_o = left_q;
  assign diag_o = diag_q;

endmodule

### rtl/lcs_length.sv
// Top level of the LCS length engine: input control, row of lcs_cell, result register.
// Depends on lcs_pkg and lcs_cell.
//
//  channel  dir  tdata                          tuser      tlast
//  s_axis   in   [7:0] symbol                   [0] mode   last
//  m_axis   out  [8:0] lcs_length, [9] a_ovfl   -          -
//
// A words (mode 0) load into the next free cell.
// B words (mode 1) are taken one per cycle unless a last B word is pending; each
// crosses the row cell by cell. An A word stalls until every B word has left the row.
// A last B word is captured in the result register as it leaves the last cell, clearing
// cells and overflow; no word is taken before then. It also waits while a result is held.
// Reset empties the row at once; no clearing pass.
module lcs_length #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  logic [0:0]  s_axis_tuser,   // [0] mode
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [8:0] lcs_length, [9] a_overflow, [15:10] zero
);
  import lcs_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LEN + 1);

  wave_ctl_t       ctl  [MAX_LEN+1];
  logic [7:0]      bsym [MAX_LEN+1];
  logic [LenW-1:0] left [MAX_LEN+1];
  logic [LenW-1:0] diag [MAX_LEN+1];
  logic            full [MAX_LEN+1];

  logic            acc, a_acc, b_acc, clr;
  logic            last_pend_q, last_pend_d;
  logic            ovf_q, ovf_d;
  logic [LenW-1:0] inflight_q, inflight_d;
  logic            out_vld_q, out_vld_d;
  logic [OutLenW-1:0] out_len_q;
  logic            out_ovf_q;

  always_comb begin
    s_axis_tready = 1'b0;
    if (!last_pend_q) begin
      if (s_axis_tuser[0]) begin
        s_axis_tready = ~s_axis_tlast | ~out_vld_q;
      end else begin
        s_axis_tready = (inflight_q == '0);
      end
    end
  end

  assign acc   = s_axis_tvalid & s_axis_tready;
  assign a_acc = acc & ~s_axis_tuser[0];
  assign b_acc = acc & s_axis_tuser[0];
  assign clr   = ctl[MAX_LEN].vld & ctl[MAX_LEN].last;

  assign ctl[0].vld  = b_acc;
  assign ctl[0].last = s_axis_tlast;
  assign bsym[0]     = s_axis_tdata;
  assign left[0]     = '0;
  assign diag[0]     = '0;
  assign full[0]     = 1'b1;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    lcs_cell #(.LenW(LenW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[i]),
      .b_i         (bsym[i]),
      .left_i      (left[i]),
      .diag_i      (diag[i]),
      .load_i      (a_acc),
      .a_sym_i     (s_axis_tdata),
      .clr_i       (clr),
      .prev_full_i (full[i]),
      .full_o      (full[i+1]),
      .ctl_o       (ctl[i+1]),
      .b_o         (bsym[i+1]),
      .left_o      (left[i+1]),
      .diag_o      (diag[i+1])
    );
  end

  always_comb begin
    last_pend_d = last_pend_q;
    if (clr) begin
      last_pend_d = 1'b0;
    end else if (b_acc & s_axis_tlast) begin
      last_pend_d = 1'b1;
    end
  end

  always_comb begin
    ovf_d = ovf_q;
    if (clr) begin
      ovf_d = 1'b0;
    end else if (a_acc & full[MAX_LEN]) begin
      ovf_d = 1'b1;
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if (b_acc & ~ctl[MAX_LEN].vld) begin
      inflight_d = inflight_q + LenW'(1);
    end else if (~b_acc & ctl[MAX_LEN].vld) begin
      inflight_d = inflight_q - LenW'(1);
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (clr) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pend_q <= 1'b0;
      ovf_q       <= 1'b0;
      inflight_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      last_pend_q <= last_pend_d;
      ovf_q       <= ovf_d;
      inflight_q  <= inflight_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr) begin
      out_len_q <= OutLenW'(left[MAX_LEN]);
      out_ovf_q <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_ovf_q, out_len_q};

endmodule

### rtl/lcs_length_chk.sv
// Port-level checks for lcs_length, attached by bind.
// Depends only on the ports of lcs_length.
module lcs_length_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed under stall");

  // no word taken right after a last B word
  a_last_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && s_axis_tlast |=> !s_axis_tready)
    else $error("word taken while a result is pending");

  // a last B word never enters while a result still waits
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |->
      !(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] && s_axis_tlast))
    else $error("second last word taken with result pending");

  // pad bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'b0)
    else $error("nonzero pad bits in result word");

endmodule

bind lcs_length lcs_length_chk u_lcs_chk (.*);

### dv/lcs_length_tb_pkg.sv
// Testbench-side codes for the LCS length engine: the word mode carried on tuser.
// No dependencies; used by lcs_length_checker and lcs_length_test.
package lcs_length_tb_pkg;

  typedef enum logic [0:0] {
    ModeLoadA   = 1'b0,
    ModeStreamB = 1'b1
  } lcs_mode_e;

endpackage

### dv/lcs_length_checker.sv
// Scoreboard for lcs_length: mirrors the A store and the match row, predicts one
// LCS length per closing B word and compares it with the output stream.
// Depends on lcs_pkg and lcs_length_tb_pkg.
module lcs_length_checker #(
  parameter int unsigned MAX_LEN = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import lcs_pkg::*;
  import lcs_length_tb_pkg::*;

  typedef struct packed {
    logic [OutLenW-1:0] length;
    logic               ovfl;
  } lcs_result_t;

  logic [SymW-1:0]    a_syms [MAX_LEN];
  logic [OutLenW-1:0] len_row [MAX_LEN];
  int unsigned        a_fill;
  logic               a_dropped;
  lcs_result_t        lcs_expected [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(string what);
    $display("[%0t] ERROR: %s", $time, what);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lcs_result_t        want;
    logic [SymW-1:0]    sym;
    logic [OutLenW-1:0] diag, left, up, cur;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_LEN; i++) len_row[i] = '0;
      a_fill    = 0;
      a_dropped = 1'b0;
      lcs_expected.delete();
    end else begin
      // results first: a word taken at this edge cannot have produced one yet
      if (m_axis_tvalid && m_axis_tready) begin
        if (lcs_expected.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", m_axis_tdata));
        end else begin
          want = lcs_expected.pop_front();
          if (m_axis_tdata[OutLenW-1:0] != want.length)
            report_mismatch($sformatf("lcs_length got %0d want %0d",
                                      m_axis_tdata[OutLenW-1:0], want.length));
          if (m_axis_tdata[OutLenW] != want.ovfl)
            report_mismatch($sformatf("a_overflow got %0b want %0b",
                                      m_axis_tdata[OutLenW], want.ovfl));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sym = s_axis_tdata;
        if (lcs_mode_e'(s_axis_tuser[0]) == ModeLoadA) begin
          if (a_fill < MAX_LEN) begin
            a_syms[a_fill]  = sym;
            len_row[a_fill] = '0;
            a_fill++;
          end else begin
            a_dropped = 1'b1;
          end
        end else begin
          diag = '0;
          left = '0;
          for (int unsigned i = 0; i < a_fill; i++) begin
            up  = len_row[i];
            cur = (a_syms[i] == sym) ? diag + 1'b1 : ((up > left) ? up : left);
            diag = up;
            len_row[i] = cur;
            left = cur;
          end
          if (s_axis_tlast) begin
            want.length = (a_fill > 0) ? len_row[a_fill-1] : '0;
            want.ovfl   = a_dropped;
            lcs_expected = {lcs_expected, want};
            for (int i = 0; i < MAX_LEN; i++) len_row[i] = '0;
            a_fill    = 0;
            a_dropped = 1'b0;
          end
        end
      end
    end
    pending_o = lcs_expected.size();
  end

endmodule

### dv/lcs_length_test.sv
// Top of the lcs_length testbench: clock, reset, A/B word stimulus, result-side
// backpressure, stall watchdog and verdict. Depends on lcs_length, lcs_length_checker
// and lcs_length_tb_pkg.
module lcs_length_test;
  import lcs_length_tb_pkg::*;

  localparam int unsigned MaxLen     = 256;
  localparam int unsigned ItemTarget = 1500;
  localparam int unsigned StallLimit = 20000;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned sent_words;
  int unsigned idle_cycles;
  int unsigned hold_cnt;
  int unsigned rx_phase;
  bit          rx_calm;
  bit          tx_calm;

  lcs_length #(.MAX_LEN(MaxLen)) u_top (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  lcs_length_checker #(.MAX_LEN(MaxLen)) u_checker (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_sym(logic [7:0] base, bit narrow);
    return narrow ? base + 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  task automatic send_word(lcs_mode_e mode, logic [7:0] sym, logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sym;
    s_axis_tuser  <= mode;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_words++;
  endtask

  // mirror: B repeats the kept A symbols in order
  task automatic run_pair(int unsigned a_n, int unsigned b_n, bit mirror);
    logic [7:0] a_seq [$];
    logic [7:0] base;
    logic [7:0] sym;
    bit         narrow;
    base   = 8'($urandom);
    narrow = $urandom_range(0, 3) != 0;
    tx_calm = $urandom_range(0, 4) == 0;
    for (int unsigned i = 0; i < a_n; i++) begin
      sym = pick_sym(base, narrow);
      a_seq = {a_seq, sym};
      send_word(ModeLoadA, sym, 1'($urandom));
    end
    for (int unsigned i = 0; i < b_n; i++) begin
      if (a_n < 64 && $urandom_range(0, 11) == 0)
        send_word(ModeLoadA, pick_sym(base, narrow), 1'($urandom));
      sym = (mirror && i < a_seq.size()) ? a_seq[i] : pick_sym(base, narrow);
      send_word(ModeStreamB, sym, i == b_n - 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_cnt      <= 0;
      rx_phase      <= 0;
      rx_calm       <= 1'b0;
    end else begin
      rx_phase <= rx_phase + 1;
      if (rx_phase % 1024 == 0) rx_calm <= $urandom_range(0, 3) == 0;
      if (hold_cnt != 0) begin
        hold_cnt      <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (!rx_calm && $urandom_range(0, 19) == 0) begin
        m_axis_tready <= 1'b0;
        case ($urandom_range(0, 19))
          0:       hold_cnt <= $urandom_range(100, 400);
          1, 2, 3: hold_cnt <= $urandom_range(5, 40);
          default: hold_cnt <= $urandom_range(0, 3);
        endcase
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned pair_idx;
    int unsigned a_n;
    int unsigned b_n;
    sent_words  = 0;
    idle_cycles = 0;
    tx_calm     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty A
    send_word(ModeStreamB, 8'h00, 1'b1);
    // extreme symbols, partial match
    send_word(ModeLoadA, 8'h00, 1'b0);
    send_word(ModeLoadA, 8'hff, 1'b0);
    send_word(ModeLoadA, 8'h55, 1'b0);
    send_word(ModeStreamB, 8'hff, 1'b0);
    send_word(ModeStreamB, 8'h00, 1'b0);
    send_word(ModeStreamB, 8'h55, 1'b1);
    // tlast on an A word is ignored
    send_word(ModeLoadA, 8'haa, 1'b1);
    send_word(ModeStreamB, 8'haa, 1'b1);
    // A symbol appended in the middle of B
    send_word(ModeLoadA, 8'h12, 1'b0);
    send_word(ModeStreamB, 8'h34, 1'b0);
    send_word(ModeLoadA, 8'h34, 1'b0);
    send_word(ModeStreamB, 8'h34, 1'b0);
    send_word(ModeStreamB, 8'h12, 1'b1);
    // no common symbol
    send_word(ModeLoadA, 8'h01, 1'b0);
    send_word(ModeLoadA, 8'h02, 1'b0);
    send_word(ModeStreamB, 8'h03, 1'b0);
    send_word(ModeStreamB, 8'h80, 1'b1);

    pair_idx = 0;
    while (sent_words < ItemTarget + 18) begin
      if (pair_idx == 2) begin
        run_pair(MaxLen + 3, MaxLen, 1'b1);        // full match plus dropped A
      end else if (pair_idx == 7) begin
        run_pair(MaxLen, 40, 1'b0);                // A exactly full
      end else begin
        if ($urandom_range(0, 11) == 0) begin
          a_n = $urandom_range(11, 80);
          b_n = $urandom_range(1, 60);
        end else begin
          a_n = $urandom_range(0, 10);
          b_n = $urandom_range(1, 10);
        end
        run_pair(a_n, b_n, $urandom_range(0, 3) == 0);
      end
      pair_idx++;
    end
    s_axis_tvalid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (MaxLen + 16) @(posedge clk_i);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
